/* rtl/cse_pkg.sv */
// Package for the C string escape encoder: item types, character codes and helpers.
package cse_pkg;

	// Depth of the queue between classifier and serialiser
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_VT     = 8'h0b;
	localparam logic [7:0] CH_FF     = 8'h0c;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7e;

	// How a source byte is rendered
	typedef enum logic [1:0] {
		CLS_PASS  = 2'd0, // byte as is
		CLS_SHORT = 2'd1, // backslash and a letter
		CLS_HEX   = 2'd2  // backslash, x, two hex digits
	} esc_cls_t;

	// One classified request in the queue
	typedef struct packed {
		esc_cls_t   cls;
		logic [7:0] data;    // raw byte, or escape letter for short form
		logic       str_end;
	} esc_item_t;

	// Escape letter for a short-escaped byte, zero if none
	function automatic logic [7:0] short_letter(input logic [7:0] b);
		logic [7:0] l;
		unique case (b)
			CH_NUL:    l = 8'h30; // '0'
			CH_BEL:    l = 8'h61; // 'a'
			CH_BS:     l = 8'h62; // 'b'
			CH_TAB:    l = 8'h74; // 't'
			CH_LF:     l = 8'h6e; // 'n'
			CH_VT:     l = 8'h76; // 'v'
			CH_FF:     l = 8'h66; // 'f'
			CH_CR:     l = 8'h72; // 'r'
			CH_DQUOTE: l = CH_DQUOTE;
			CH_SQUOTE: l = CH_SQUOTE;
			CH_BSLASH: l = CH_BSLASH;
			default:   l = 8'h00;
		endcase
		return l;
	endfunction

	// Lowercase hex digit of a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = CH_ZERO + {4'h0, n};
		end else begin
			c = 8'h57 + {4'h0, n}; // 'a' - 10
		end
		return c;
	endfunction

endpackage

/* rtl/cse_if.sv */
// Valid/ready channel interfaces for the input bytes and the escaped output bytes.
interface cse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_end;

	modport source (output valid, output in_byte, output string_end, input ready);
	modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface cse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_done;

	modport source (output valid, output out_byte, output run_last, output string_done,
		input ready);
	modport sink   (input valid, input out_byte, input run_last, input string_done,
		output ready);
endinterface

/* rtl/cse_front.sv */
// Front end: accepts source bytes and classifies them into escape requests.
module cse_front (
	input  logic                clk,
	input  logic                arst_n,
	cse_in_if.sink              in_ch,
	output logic                item_valid,
	output cse_pkg::esc_item_t  item,
	input  logic                item_ready
);
	import cse_pkg::*;

	logic       valid_s1;
	esc_item_t  item_s1;
	esc_item_t  item_d;
	logic [7:0] letter;

	// Stage can take a request when empty or when it drains this cycle
	assign in_ch.ready = !valid_s1 || item_ready;

	// Classification
	always_comb begin
		letter = short_letter(in_ch.in_byte);
		item_d.str_end = in_ch.string_end;
		if (letter != 8'h00) begin
			item_d.cls  = CLS_SHORT;
			item_d.data = letter;
		end else if (in_ch.in_byte >= CH_PRINT_LO && in_ch.in_byte <= CH_PRINT_HI) begin
			item_d.cls  = CLS_PASS;
			item_d.data = in_ch.in_byte;
		end else begin
			item_d.cls  = CLS_HEX;
			item_d.data = in_ch.in_byte;
		end
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= item_d;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

/* rtl/cse_queue.sv */
// Short queue of classified requests between the front end and the serialiser.
module cse_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cse_pkg::esc_item_t  push_item,
	output logic                not_full,
	input  logic                pop,
	output logic                head_valid,
	output cse_pkg::esc_item_t  head_item
);
	import cse_pkg::*;

	esc_item_t        entry_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full   = (count_q != Q_CW'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign do_push    = push && not_full;
	assign do_pop     = pop && head_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/cse_back.sv */
// Back end: walks each request through its escape sequence into the output register.
module cse_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  cse_pkg::esc_item_t  head_item,
	output logic                pop,
	cse_out_if.source           out_ch
);
	import cse_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       string_done_q;
	logic       load;
	logic [7:0] cur_byte;
	logic       cur_last;

	// Output register frees up when empty or taken
	assign load = !out_valid_q || out_ch.ready;
	assign pop  = load && head_valid && cur_last;

	// Byte at the current position of the sequence
	always_comb begin
		case (idx_q)
			2'd0:    cur_byte = (head_item.cls == CLS_PASS) ? head_item.data : CH_BSLASH;
			2'd1:    cur_byte = (head_item.cls == CLS_SHORT) ? head_item.data : CH_X;
			2'd2:    cur_byte = hex_char(head_item.data[7:4]);
			default: cur_byte = hex_char(head_item.data[3:0]);
		endcase
	end

	// End of run depends on the form
	always_comb begin
		unique case (head_item.cls)
			CLS_PASS:  cur_last = (idx_q == 2'd0);
			CLS_SHORT: cur_last = (idx_q == 2'd1);
			CLS_HEX:   cur_last = (idx_q == 2'd3);
			default:   cur_last = 1'b1;
		endcase
	end

	// Sequence position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= cur_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_byte_q    <= cur_byte;
			run_last_q    <= cur_last;
			string_done_q <= cur_last && head_item.str_end;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.run_last    = run_last_q;
	assign out_ch.string_done = string_done_q;

endmodule

/* rtl/c_string_escape_encoder.sv */
// Top level of the C string escape encoder.
//
// in_ch takes one source byte per request (in_byte, string_end) on a
// valid/ready handshake. out_ch gives the escaped text one byte per request:
// out_byte, run_last on the final byte of each source byte's run, and
// string_done on that final byte when string_end was set.
// Printable bytes pass as one byte; quotes, backslash and the common control
// characters give two bytes; all others give four (backslash, x, two hex).
// Path: a byte accepted on in_ch is registered in the classify stage, pushed
// into the queue, then taken from the queue head into the output register.
// Throughput: one output byte per cycle while out_ch is ready; a source byte
// gives out its whole run before the next one starts, so plain text runs at
// one byte per cycle. The serialiser is the limit; the two-entry queue lets
// the front end keep accepting while a long run drains.
// Reset clears all valid flags and the run position; nothing is output until
// a new byte arrives. When the receiver stalls, the output register holds its
// byte, the queue fills, and then in_ch.ready falls.
module c_string_escape_encoder (
	input  logic       clk,
	input  logic       arst_n,
	cse_in_if.sink     in_ch,
	cse_out_if.source  out_ch
);
	import cse_pkg::*;

	logic       front_valid;
	esc_item_t  front_item;
	logic       q_not_full;
	logic       head_valid;
	esc_item_t  head_item;
	logic       pop;

	cse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.item_valid (front_valid),
		.item       (front_item),
		.item_ready (q_not_full)
	);

	cse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid),
		.push_item  (front_item),
		.not_full   (q_not_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	cse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

/* rtl/cse_checker.sv */
// Port-level checks on the C string escape encoder, bound to the top level.
module cse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       string_done
);
	import cse_pkg::*;

	// No output while reset is applied
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// A stalled output byte stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
			&& $stable(string_done))
		else $error("stalled output changed");

	// String end only ever marks the end of a run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_done |-> run_last)
		else $error("string_done without run_last");

	// Bytes inside a run are backslash, x or lowercase hex digits
	a_inner_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |->
			out_byte == CH_BSLASH || out_byte == CH_X
			|| (out_byte >= 8'h30 && out_byte <= 8'h39)
			|| (out_byte >= 8'h61 && out_byte <= 8'h66))
		else $error("unexpected byte inside an escape run");

endmodule

bind c_string_escape_encoder cse_checker u_cse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_byte    (out_ch.out_byte),
	.run_last    (out_ch.run_last),
	.string_done (out_ch.string_done)
);

/* tb/sv/cse_escape_checker.sv */
// Checker for the C string escape encoder: predicts escaped runs and compares output bytes.
`timescale 1ns / 100ps

module cse_escape_checker
	import cse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cse_in_if         in_mon,
	cse_out_if        out_mon,
	output int        fail_count,
	output int        pending
);

	// One expected output byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
	} esc_char_t;

	esc_char_t escaped_q[$];
	int        mismatch_cnt;

	initial begin
		fail_count   = 0;
		pending      = 0;
		mismatch_cnt = 0;
	end

	// Lowercase hex digit of a nibble
	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = "0" + {4'h0, n};
		end else begin
			c = "a" + {4'h0, n} - 8'd10;
		end
		return c;
	endfunction

	// Work out the escaped run of one source byte and queue it
	function automatic void queue_escape_run(input logic [7:0] b, input logic str_end);
		logic [7:0] run[4];
		logic [7:0] letter;
		int         len;
		esc_char_t  c;
		case (b)
			CH_NUL:    letter = "0";
			CH_BEL:    letter = "a";
			CH_BS:     letter = "b";
			CH_TAB:    letter = "t";
			CH_LF:     letter = "n";
			CH_VT:     letter = "v";
			CH_FF:     letter = "f";
			CH_CR:     letter = "r";
			CH_DQUOTE: letter = CH_DQUOTE;
			CH_SQUOTE: letter = CH_SQUOTE;
			CH_BSLASH: letter = CH_BSLASH;
			default:   letter = 8'h00;
		endcase
		if (letter != 8'h00) begin
			run[0] = CH_BSLASH;
			run[1] = letter;
			len    = 2;
		end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
			run[0] = b;
			len    = 1;
		end else begin
			run[0] = CH_BSLASH;
			run[1] = CH_X;
			run[2] = nibble_char(b[7:4]);
			run[3] = nibble_char(b[3:0]);
			len    = 4;
		end
		for (int k = 0; k < len; k++) begin
			c.out_byte    = run[k];
			c.run_last    = (k == len - 1);
			c.string_done = (k == len - 1) && str_end;
			escaped_q.push_back(c);
		end
	endfunction

	// Watch both channels; requests go in before results come out
	always @(posedge clk) begin
		esc_char_t want;
		if (arst_n) begin
			if (in_mon.valid && in_mon.ready) begin
				queue_escape_run(in_mon.in_byte, in_mon.string_end);
			end
			if (out_mon.valid && out_mon.ready) begin
				if (escaped_q.size() == 0) begin
					fail_count = fail_count + 1;
					if (mismatch_cnt < 10) begin
						$display("%0t: unexpected output byte %h last=%b done=%b", $realtime,
							out_mon.out_byte, out_mon.run_last, out_mon.string_done);
					end
					mismatch_cnt = mismatch_cnt + 1;
				end else begin
					want = escaped_q.pop_front();
					if (out_mon.out_byte !== want.out_byte ||
						out_mon.run_last !== want.run_last ||
						out_mon.string_done !== want.string_done) begin
						fail_count = fail_count + 1;
						if (mismatch_cnt < 10) begin
							$display("%0t: mismatch byte exp %h got %h, last exp %b got %b, done exp %b got %b",
								$realtime, want.out_byte, out_mon.out_byte, want.run_last,
								out_mon.run_last, want.string_done, out_mon.string_done);
						end
						mismatch_cnt = mismatch_cnt + 1;
					end
				end
			end
		end
		pending <= escaped_q.size();
	end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the C string escape encoder: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb;
	import cse_pkg::*;

	localparam int N_RANDOM   = 310;
	localparam int HOLD_LEN   = 150;
	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles;
	bit   hold_go;
	bit   hold_done;

	cse_in_if  in_ch();
	cse_out_if out_ch();

	c_string_escape_encoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	cse_escape_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: changing stall patterns, plus one long hold-off
	initial begin
		int mode;
		int stretch;
		hold_done = 1'b0;
		out_ch.ready <= 1'b0;
		mode    = 0;
		stretch = 0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else begin
				if (stretch == 0) begin
					mode    = $urandom_range(0, 3);
					stretch = $urandom_range(16, 96);
				end
				stretch = stretch - 1;
				case (mode)
					0:       out_ch.ready <= 1'b1;
					1:       out_ch.ready <= 1'($urandom_range(0, 1));
					2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: out_ch.ready <= (cycles % 2 == 0);
				endcase
			end
		end
	end

	// Offer one request and wait until it is taken
	task automatic offer(input logic [7:0] b, input logic e);
		in_ch.valid      <= 1'b1;
		in_ch.in_byte    <= b;
		in_ch.string_end <= e;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drop valid for a number of cycles
	task automatic idle(input int n);
		if (n > 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Pause until every expected byte has come out
	task automatic drain();
		idle(1);
		while (pending != 0) @(posedge clk);
	endtask

	// Random source byte, weighted over the escape classes
	function automatic logic [7:0] pick_byte();
		logic [7:0] esc_set[11] = '{CH_NUL, CH_BEL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF,
			CH_CR, CH_DQUOTE, CH_SQUOTE, CH_BSLASH};
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: b = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
			1: b = esc_set[$urandom_range(0, 10)];
			2: b = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h00, 8'h1f))
				: 8'($urandom_range(8'h7f, 8'hff));
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	// Stimulus and verdict
	initial begin
		logic [7:0] directed[22];
		int sent;
		int burst;
		directed = '{CH_NUL, CH_BEL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
			CH_DQUOTE, CH_SQUOTE, CH_BSLASH, CH_PRINT_LO, CH_PRINT_HI, 8'h7f, 8'h80, 8'hff,
			8'he9, 8'h41, 8'h01, 8'h1f, 8'h06, 8'h0e};
		hold_go = 1'b0;
		arst_n           <= 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.in_byte    <= 8'h00;
		in_ch.string_end <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every escape letter, print range edges, DEL, high bytes
		for (int i = 0; i < 22; i++) begin
			offer(directed[i], (i % 4 == 3) || (i == 21));
			if (i % 7 == 6) idle(2);
		end
		drain();

		// Random bursts
		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
				offer(pick_byte(), $urandom_range(0, 7) == 0);
				sent = sent + 1;
				if (sent == 40) hold_go = 1'b1;
				if (sent == 160) drain();
			end
			idle(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
